@@ sv/fcmp_pkg.sv @@
package fcmp_pkg;

    // register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 2'd2;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CNT_W      = 4;   // fraction digit count, up to 9

    localparam logic [7:0] RESET_START     = 8'd35;
    localparam logic [7:0] RESET_SEPARATOR = 8'd92;
    localparam logic [31:0] RESET_MARKER   = 32'h5C6E_5C72;
    localparam logic [7:0] POINT_CHAR      = 8'h2E;
    localparam logic [8:0] DIGIT_BIAS      = 9'd48;
    localparam logic [8:0] EMPTY_CHAR      = 9'h1D0;   // -48

    // field being parsed
    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LON  = 3'b010,
        PH_LAT  = 3'b100
    } phase_t;

    // one decimal number under construction, already scaled
    typedef struct packed {
        logic [31:0]      int_s;   // integer part times 10^FRAC_DIGITS
        logic [31:0]      frac_s;  // fraction part scaled to FRAC_DIGITS places
        logic [CNT_W-1:0] cnt;
        logic             point;
    } num_t;

    // frame summary waiting for the final add
    typedef struct packed {
        logic [8:0] msg_type;
        logic [8:0] body;
        num_t       lon;
        num_t       lat;
    } partial_t;

    function automatic logic [31:0] pow10(input logic [CNT_W-1:0] n);
        logic [31:0] r;
        unique case (n)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/fcmp_rx_if.sv @@
interface fcmp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/fcmp_result_if.sv @@
interface fcmp_result_if;
    logic               valid;
    logic               ready;
    logic signed [8:0]  message_type;
    logic signed [8:0]  body_digit;
    logic signed [31:0] longitude_micro;
    logic signed [31:0] latitude_micro;

    modport source (output valid, output message_type, output body_digit,
                    output longitude_micro, output latitude_micro, input ready);
    modport sink   (input valid, input message_type, input body_digit,
                    input longitude_micro, input latitude_micro, output ready);
endinterface

@@ sv/framed_coordinate_message_parser_unit.sv @@
// Channel  | Dir | Payload                                           | Word
// ---------+-----+---------------------------------------------------+-------------------
// rx       | in  | rx_byte[7:0]                                      | one received byte
// result   | out | message_type, body_digit (s9), longitude_micro,   | one completed frame
//          |     | latitude_micro (s32)                              |
// cfg      | in  | cfg_write, cfg_index[1:0], cfg_data[31:0]         | one register write
//
// Cycles: one byte per cycle sustained until a held result fills all stages. A frame
//   result follows the byte that completes the end marker through input reg, frame reg and sum reg.
// Reset: rst_n async low; parser idle until a start byte, registers at defaults.
// Stalls: result.ready low holds the sum stage; the frame stage and input
//   register keep filling, rx.ready drops only once all three stages are full.
module framed_coordinate_message_parser_unit #(
    parameter int unsigned END_LEN     = 4,   // end marker length, 1..4
    parameter int unsigned FRAC_DIGITS = 6    // kept fraction digits, 1..9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fcmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcmp_pkg::CFG_DATA_W-1:0]   cfg_data,
    fcmp_rx_if.sink                           rx,
    fcmp_result_if.source                     result
);

    localparam int unsigned FILL_W = $clog2(END_LEN + 1);
    localparam logic [31:0] INT_SCALE = fcmp_pkg::pow10(fcmp_pkg::CNT_W'(FRAC_DIGITS));
    localparam logic [fcmp_pkg::CNT_W-1:0] FRAC_MAX = fcmp_pkg::CNT_W'(FRAC_DIGITS);
    localparam logic [fcmp_pkg::CNT_W-1:0] FRAC_TOP = fcmp_pkg::CNT_W'(FRAC_DIGITS - 1);

    // ---------------- configuration registers ----------------
    logic [7:0]  start_reg;
    logic [7:0]  sep_reg;
    logic [31:0] marker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= fcmp_pkg::RESET_START;
            sep_reg    <= fcmp_pkg::RESET_SEPARATOR;
            marker_reg <= fcmp_pkg::RESET_MARKER;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcmp_pkg::CFG_START_BYTE: start_reg  <= cfg_data[7:0];
                fcmp_pkg::CFG_SEPARATOR:  sep_reg    <= cfg_data[7:0];
                fcmp_pkg::CFG_END_MARKER: marker_reg <= cfg_data;
                default: ;   // unmapped index, ignored
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    // A: input byte register, B: frame summary register, C: result register
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       b_valid_reg;
    logic       c_valid_reg;
    logic       c_free;
    logic       b_free;
    logic       proc;
    logic       emit;

    assign c_free   = !c_valid_reg || result.ready;
    assign b_free   = !b_valid_reg || c_free;
    assign proc     = a_valid_reg && b_free;
    assign rx.ready = !a_valid_reg || b_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            a_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            a_byte_reg <= rx.rx_byte;
        end
    end

    // ---------------- frame state ----------------
    logic              in_frame_reg, in_frame_next;
    logic [7:0]        win_reg  [END_LEN];
    logic [7:0]        win_next [END_LEN];
    logic [FILL_W-1:0] fill_reg, fill_next;
    fcmp_pkg::phase_t  phase_reg, phase_next;
    logic [8:0]        type_reg, type_next;
    logic [8:0]        body_reg, body_next;
    logic              seen_type_reg, seen_type_next;
    logic              seen_body_reg, seen_body_next;
    fcmp_pkg::num_t    lon_reg, lon_next;
    fcmp_pkg::num_t    lat_reg, lat_next;

    // parse datapath: the byte leaving the window
    logic [7:0]        pb;
    logic [8:0]        d9;
    logic [31:0]       d32;
    logic [31:0]       int_add;
    logic [31:0]       frac_add;
    fcmp_pkg::num_t    num_sel;
    fcmp_pkg::num_t    num_upd;
    logic              is_start;
    logic              match;

    assign pb       = win_reg[0];
    assign d9       = {1'b0, pb} - fcmp_pkg::DIGIT_BIAS;
    assign d32      = {{23{d9[8]}}, d9};
    assign num_sel  = (phase_reg == fcmp_pkg::PH_LAT) ? lat_reg : lon_reg;
    assign int_add  = d32 * INT_SCALE;
    assign frac_add = d32 * fcmp_pkg::pow10(FRAC_TOP - num_sel.cnt);
    assign is_start = (a_byte_reg == start_reg);

    // one decimal text step; first point splits integer and fraction
    always_comb
    begin
        num_upd = num_sel;
        if (!num_sel.point && pb == fcmp_pkg::POINT_CHAR)
        begin
            num_upd.point = 1'b1;
        end
        else if (!num_sel.point)
        begin
            num_upd.int_s = (num_sel.int_s << 3) + (num_sel.int_s << 1) + int_add;
        end
        else if (num_sel.cnt < FRAC_MAX)
        begin
            num_upd.frac_s = num_sel.frac_s + frac_add;
            num_upd.cnt    = num_sel.cnt + 1'b1;
        end
    end

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        type_next      = type_reg;
        body_next      = body_reg;
        seen_type_next = seen_type_reg;
        seen_body_next = seen_body_reg;
        lon_next       = lon_reg;
        lat_next       = lat_reg;
        match          = 1'b0;
        emit           = 1'b0;

        if (is_start)
        begin
            // open or restart: everything clears
            in_frame_next = 1'b1;
            for (int i = 0; i < END_LEN; i++)
            begin
                win_next[i] = 8'd0;
            end
            fill_next      = '0;
            phase_next     = fcmp_pkg::PH_TYPE;
            type_next      = fcmp_pkg::EMPTY_CHAR;
            body_next      = fcmp_pkg::EMPTY_CHAR;
            seen_type_next = 1'b0;
            seen_body_next = 1'b0;
            lon_next       = '0;
            lat_next       = '0;
        end
        else if (in_frame_reg)
        begin
            if (fill_reg == FILL_W'(END_LEN))
            begin
                // oldest byte can no longer be marker: parse it
                unique case (phase_reg)
                    fcmp_pkg::PH_TYPE:
                    begin
                        if (pb == sep_reg)
                        begin
                            phase_next = fcmp_pkg::PH_LON;
                        end
                        else if (!seen_type_reg)
                        begin
                            type_next      = d9;
                            seen_type_next = 1'b1;
                        end
                    end
                    fcmp_pkg::PH_LON:
                    begin
                        // body char is taken even when it is the separator
                        if (!seen_body_reg)
                        begin
                            body_next      = d9;
                            seen_body_next = 1'b1;
                        end
                        if (pb == sep_reg)
                        begin
                            phase_next = fcmp_pkg::PH_LAT;
                        end
                        else
                        begin
                            lon_next = num_upd;
                        end
                    end
                    fcmp_pkg::PH_LAT:
                    begin
                        lat_next = num_upd;
                    end
                    default: ;
                endcase
                for (int i = 0; i < END_LEN - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[END_LEN - 1] = a_byte_reg;
            end
            else
            begin
                for (int i = 0; i < END_LEN; i++)
                begin
                    if (fill_reg == FILL_W'(i))
                    begin
                        win_next[i] = a_byte_reg;
                    end
                end
                fill_next = fill_reg + 1'b1;
            end

            match = (fill_next == FILL_W'(END_LEN));
            for (int i = 0; i < END_LEN; i++)
            begin
                if (win_next[i] != marker_reg[8 * (END_LEN - 1 - i) +: 8])
                begin
                    match = 1'b0;
                end
            end
            if (match)
            begin
                emit          = 1'b1;
                in_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            fill_reg      <= '0;
            phase_reg     <= fcmp_pkg::PH_TYPE;
            seen_type_reg <= 1'b0;
            seen_body_reg <= 1'b0;
            type_reg      <= fcmp_pkg::EMPTY_CHAR;
            body_reg      <= fcmp_pkg::EMPTY_CHAR;
            lon_reg       <= '0;
            lat_reg       <= '0;
            for (int i = 0; i < END_LEN; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else if (proc)
        begin
            in_frame_reg  <= in_frame_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            seen_type_reg <= seen_type_next;
            seen_body_reg <= seen_body_next;
            type_reg      <= type_next;
            body_reg      <= body_next;
            lon_reg       <= lon_next;
            lat_reg       <= lat_next;
            win_reg       <= win_next;
        end
    end

    // ---------------- stage B: frame summary ----------------
    fcmp_pkg::partial_t b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && emit)
        begin
            b_reg.msg_type <= type_next;
            b_reg.body     <= body_next;
            b_reg.lon      <= lon_next;
            b_reg.lat      <= lat_next;
        end
    end

    // ---------------- stage C: integer plus fraction ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free && b_valid_reg)
        begin
            result.message_type    <= b_reg.msg_type;
            result.body_digit      <= b_reg.body;
            result.longitude_micro <= b_reg.lon.int_s + b_reg.lon.frac_s;
            result.latitude_micro  <= b_reg.lat.int_s + b_reg.lat.frac_s;
        end
    end

    assign result.valid = c_valid_reg;

    // ---------------- checks ----------------
    // input stalls only with every stage full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (a_valid_reg && b_valid_reg && c_valid_reg))
        else $error("input stalled with a free stage");

    // a completed frame closes the parser
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && emit) |=> (!in_frame_reg && b_valid_reg))
        else $error("frame still open after result");

    // a start byte opens a fresh frame
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_start) |=> (in_frame_reg && fill_reg == '0 && !b_valid_reg
                                 ? 1'b1 : (in_frame_reg && fill_reg == '0)))
        else $error("start byte did not reset frame");

    // frame summary waits while the result is held
    a_b_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !c_free) |=> (b_valid_reg && $stable(b_reg)))
        else $error("frame summary lost under stall");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the unit under test (defaults of the top level).
    localparam int MARK_LEN  = 4;
    localparam int FRAC_KEEP = 6;

    // The result follows the last marker byte through the pipeline registers; allow margin.
    localparam int DRAIN_CYCLES = 10;
    // Long receiver hold-off, long enough to back the unit up into rx.
    localparam int LONG_HOLD    = 300;
    // Random words to send before the run may stop, and frames to see.
    localparam int RANDOM_WORDS = 950;
    localparam int MIN_FRAMES   = 60;

    // One completed frame as seen on the result channel.
    typedef struct packed {
        logic signed [8:0]  message_type;
        logic signed [8:0]  body_digit;
        logic signed [31:0] longitude_micro;
        logic signed [31:0] latitude_micro;
    } frame_fields_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [fcmp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fcmp_pkg::CFG_DATA_W-1:0] cfg_data;

    fcmp_rx_if     rx_ch ();
    fcmp_result_if res_ch ();

    framed_coordinate_message_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .result    (res_ch)
    );

    // ------------------------------------------------------------------
    // Frame predictor: its own copy of the registers and parse state.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_start;
    logic [7:0]  cfg_sep;
    logic [31:0] cfg_marker;

    bit                framing;          // inside a frame, start byte seen
    logic [7:0]        tail_bytes [4];   // bytes held back until they cannot be marker
    int                tail_count;
    fcmp_pkg::phase_t  parse_phase;
    logic [8:0]        type_char;
    logic [8:0]        body_char;
    bit                type_seen;
    bit                body_seen;
    logic [31:0]       int_acc   [2];    // 0 longitude, 1 latitude
    logic [31:0]       frac_acc  [2];
    int                frac_cnt  [2];
    bit                point_in  [2];

    frame_fields_t pending_frames [$];

    int error_count;
    int frames_checked;
    int random_words;
    bit sender_idles;
    bit receiver_idles;
    bit hold_request;

    function automatic void clear_frame_state();
        int i;
        for (i = 0; i < 4; i++)
            tail_bytes[i] = 8'd0;
        tail_count  = 0;
        parse_phase = fcmp_pkg::PH_TYPE;
        type_char   = fcmp_pkg::EMPTY_CHAR;
        body_char   = fcmp_pkg::EMPTY_CHAR;
        type_seen   = 1'b0;
        body_seen   = 1'b0;
        for (i = 0; i < 2; i++)
        begin
            int_acc[i]  = 32'd0;
            frac_acc[i] = 32'd0;
            frac_cnt[i] = 0;
            point_in[i] = 1'b0;
        end
    endfunction

    function automatic logic [7:0] marker_byte(int i);
        return cfg_marker[8*(MARK_LEN-1-i) +: 8];
    endfunction

    function automatic logic [31:0] ten_pow(int n);
        logic [31:0] p;
        p = 32'd1;
        repeat (n) p = p * 32'd10;
        return p;
    endfunction

    // Every byte is a digit of value (byte - 48); only the first point splits.
    function automatic void accumulate_digit(int f, logic [7:0] b);
        logic [31:0] d;
        d = {24'd0, b} - 32'd48;
        if (!point_in[f] && b == fcmp_pkg::POINT_CHAR)
        begin
            point_in[f] = 1'b1;
            return;
        end
        if (!point_in[f])
            int_acc[f] = int_acc[f] * 32'd10 + d;
        else if (frac_cnt[f] < FRAC_KEEP)
        begin
            frac_acc[f] = frac_acc[f] * 32'd10 + d;
            frac_cnt[f]++;
        end
    endfunction

    function automatic void parse_field_byte(logic [7:0] b);
        case (parse_phase)
            fcmp_pkg::PH_TYPE:
            begin
                if (b == cfg_sep)
                    parse_phase = fcmp_pkg::PH_LON;
                else if (!type_seen)
                begin
                    type_char = {1'b0, b} - fcmp_pkg::DIGIT_BIAS;
                    type_seen = 1'b1;
                end
            end
            fcmp_pkg::PH_LON:
            begin
                // first body byte is kept even when it is the separator
                if (!body_seen)
                begin
                    body_char = {1'b0, b} - fcmp_pkg::DIGIT_BIAS;
                    body_seen = 1'b1;
                end
                if (b == cfg_sep)
                    parse_phase = fcmp_pkg::PH_LAT;
                else
                    accumulate_digit(0, b);
            end
            default:
                accumulate_digit(1, b);
        endcase
    endfunction

    function automatic logic [31:0] scaled_value(int f);
        return int_acc[f] * ten_pow(FRAC_KEEP)
             + frac_acc[f] * ten_pow(FRAC_KEEP - frac_cnt[f]);
    endfunction

    // Applies one accepted rx word; returns 1 when it closes a frame.
    function automatic bit parse_rx_byte(logic [7:0] b, output frame_fields_t r);
        int  i;
        bit  hit;
        r = '0;
        if (b == cfg_start)
        begin
            framing = 1'b1;
            clear_frame_state();
            return 1'b0;
        end
        if (!framing)
            return 1'b0;
        if (tail_count >= MARK_LEN)
        begin
            parse_field_byte(tail_bytes[0]);
            for (i = 0; i < 3; i++)
                tail_bytes[i] = tail_bytes[i+1];
            tail_count = MARK_LEN - 1;
        end
        tail_bytes[tail_count] = b;
        tail_count++;
        if (tail_count != MARK_LEN)
            return 1'b0;
        hit = 1'b1;
        for (i = 0; i < MARK_LEN; i++)
            if (tail_bytes[i] != marker_byte(i))
                hit = 1'b0;
        if (!hit)
            return 1'b0;
        r.message_type    = type_char;
        r.body_digit      = body_char;
        r.longitude_micro = scaled_value(0);
        r.latitude_micro  = scaled_value(1);
        framing = 1'b0;
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        if (r < 92)
            return $urandom_range(2, 4);
        return $urandom_range(8, 40);
    endfunction

    // Number text: mostly digits, some points and separators, some raw bytes.
    function automatic logic [7:0] rand_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 76)
            return 8'h30 + 8'($urandom_range(0, 9));
        if (r < 86)
            return fcmp_pkg::POINT_CHAR;
        if (r < 90)
            return cfg_sep;
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Clock, time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready pattern, with a long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin : result_ready_driver
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (receiver_idles && $urandom_range(0, 3) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (rand_gap()) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    function automatic void compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Every accepted result word is matched against the oldest predicted frame.
    always @(posedge clk)
    begin : result_check
        frame_fields_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected result word, type %0d body %0d lon %0d lat %0d",
                         $time, res_ch.message_type, res_ch.body_digit,
                         res_ch.longitude_micro, res_ch.latitude_micro);
                error_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("message_type", want.message_type, res_ch.message_type);
                compare_field("body_digit", want.body_digit, res_ch.body_digit);
                compare_field("longitude_micro", want.longitude_micro,
                              res_ch.longitude_micro);
                compare_field("latitude_micro", want.latitude_micro,
                              res_ch.latitude_micro);
            end
            frames_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Offers one rx word, predicts on acceptance, then maybe idles.
    // Called right after a rising edge.
    task automatic send_rx_byte(input logic [7:0] b);
        frame_fields_t r;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (rx_ch.ready !== 1'b1);
        if (parse_rx_byte(b, r))
            pending_frames.push_back(r);
        if (sender_idles && $urandom_range(0, 2) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (rand_gap()) @(posedge clk);
        end
    endtask

    task automatic send_word_list(input logic [7:0] q [$]);
        foreach (q[i])
            send_rx_byte(q[i]);
    endtask

    // Sender stops, every predicted frame arrives, then the pipe settles.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // All three registers back to back; upper data bits of the byte
    // registers carry noise, the unit keeps only the low byte.
    task automatic write_config(input logic [7:0] start_val, input logic [7:0] sep_val,
                                input logic [31:0] marker_val);
        cfg_write <= 1'b1;
        cfg_index <= fcmp_pkg::CFG_START_BYTE;
        cfg_data  <= {24'($urandom), start_val};
        @(posedge clk);
        cfg_index <= fcmp_pkg::CFG_SEPARATOR;
        cfg_data  <= {24'($urandom), sep_val};
        @(posedge clk);
        cfg_index <= fcmp_pkg::CFG_END_MARKER;
        cfg_data  <= marker_val;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_start  = start_val;
        cfg_sep    = sep_val;
        cfg_marker = marker_val;
    endtask

    // One frame with random content under the current registers. Most are
    // well formed; some carry leading noise, a restart, a missing type
    // separator, no latitude, or a cut-off marker.
    task automatic send_random_frame();
        logic [7:0] q [$];
        int style;
        int n;
        int k;
        style = $urandom_range(0, 19);
        if (style == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) q.push_back(8'($urandom_range(0, 255)));
        end
        q.push_back(cfg_start);
        n = $urandom_range(0, 2);
        repeat (n) q.push_back(rand_text_char());
        if ($urandom_range(0, 9) != 0)
            q.push_back(cfg_sep);
        for (k = 0; k < 2; k++)
        begin
            if (k == 1)
            begin
                if ($urandom_range(0, 4) == 0)
                    break;
                q.push_back(cfg_sep);
            end
            // long texts push the accumulators past 32 bits
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
            repeat (n) q.push_back(rand_text_char());
        end
        if (style == 1)
            q.insert($urandom_range(1, q.size()), cfg_start);
        n = (style == 2) ? $urandom_range(0, MARK_LEN - 1) : MARK_LEN;
        for (k = 0; k < n; k++)
            q.push_back(marker_byte(k));
        random_words += q.size();
        send_word_list(q);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-built frames under the reset registers: idle bytes, a
    // restart, an empty frame, the separator as first body byte, repeated
    // points and a separator in the latitude, a frame with no type separator,
    // and the byte extremes.
    task automatic test_directed_frames();
        logic [7:0] q [$];
        int k;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        // ignored while idle, then '5' dropped by the restart: empty frame
        q = '{8'h00, 8'hFF, cfg_start, 8'h35, cfg_start};
        for (k = 0; k < MARK_LEN; k++)
            q.push_back(marker_byte(k));
        // no type, body opens with the separator, latitude "1..\2"
        q.push_back(cfg_start);
        q.push_back(cfg_sep);
        q.push_back(cfg_sep);
        q.push_back(8'h31);
        q.push_back(fcmp_pkg::POINT_CHAR);
        q.push_back(fcmp_pkg::POINT_CHAR);
        q.push_back(cfg_sep);
        q.push_back(8'h32);
        for (k = 0; k < MARK_LEN; k++)
            q.push_back(marker_byte(k));
        // whole frame is type: '7', 0xFF, 0x00
        q.push_back(cfg_start);
        q.push_back(8'h37);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        for (k = 0; k < MARK_LEN; k++)
            q.push_back(marker_byte(k));
        send_word_list(q);
        drain_results();
    endtask

    // Receiver holds off for a long stretch while frames keep coming, so the
    // unit fills and drops rx ready; then the sender waits for every result.
    task automatic test_output_backpressure();
        int i;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 1'b1;
        for (i = 0; i < 12; i++)
            send_random_frame();
        drain_results();
    endtask

    // Random frames under extreme, random and reset register settings.
    task automatic test_register_settings();
        logic [7:0]  start_val;
        logic [31:0] marker_val;
        int setting;
        int k;
        int phase_start;
        for (setting = 0; setting < 4; setting++)
        begin
            drain_results();
            case (setting)
                0: write_config(8'h00, 8'hFF, 32'hFFFF_FFFF);
                1: write_config(8'hFF, 8'h00, 32'h0000_0000);
                2:
                begin
                    // marker bytes kept clear of the start byte so frames close
                    start_val = 8'($urandom_range(0, 255));
                    for (k = 0; k < 4; k++)
                        do marker_val[8*k +: 8] = 8'($urandom_range(0, 255));
                        while (marker_val[8*k +: 8] == start_val);
                    write_config(start_val, 8'($urandom_range(0, 255)), marker_val);
                end
                default: write_config(fcmp_pkg::RESET_START, fcmp_pkg::RESET_SEPARATOR,
                                      fcmp_pkg::RESET_MARKER);
            endcase
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
            phase_start    = random_words;
            while (random_words - phase_start < 100)
                send_random_frame();
        end
        drain_results();
    endtask

    // Bulk random traffic; idling switches on and off in stretches and the
    // sender sometimes waits for the unit to empty.
    task automatic test_random_traffic();
        int frame_no;
        frame_no = 0;
        while (random_words < RANDOM_WORDS || frames_checked < MIN_FRAMES)
        begin
            if (frame_no % 8 == 0)
            begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            if (frame_no % 25 == 24)
                drain_results();
            send_random_frame();
            frame_no++;
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= fcmp_pkg::CFG_START_BYTE;
        cfg_data      <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        error_count    = 0;
        frames_checked = 0;
        random_words   = 0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 1'b0;
        cfg_start      = fcmp_pkg::RESET_START;
        cfg_sep        = fcmp_pkg::RESET_SEPARATOR;
        cfg_marker     = fcmp_pkg::RESET_MARKER;
        framing        = 1'b0;
        clear_frame_state();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_output_backpressure();
        test_register_settings();
        test_random_traffic();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fcmp_pkg.sv
sv/fcmp_rx_if.sv
sv/fcmp_result_if.sv
sv/framed_coordinate_message_parser_unit.sv
tb/tb_top.sv
